// File: sv/median7_ema_level_classifier_core_assert.svh
// Assertion macros for the median/EMA level classifier core.
// Expects clk and rst_n in the scope of the use.
`ifndef MEDIAN7_EMA_LEVEL_CLASSIFIER_CORE_ASSERT_SVH
`define MEDIAN7_EMA_LEVEL_CLASSIFIER_CORE_ASSERT_SVH

// same-cycle implication
`define M7EC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("m7ec assertion failed");

// next-cycle implication
`define M7EC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("m7ec assertion failed");

`endif

// File: sv/m7ec_pkg.sv
// Shared constants, types and the level classifier for the m7ec core.
// No dependencies.
package m7ec_pkg;

    localparam int BATCH_SIZE   = 7;
    localparam int SAMPLE_WIDTH = 16;
    localparam int MEDIAN_IDX   = BATCH_SIZE / 2;
    localparam int FILL_W       = $clog2(BATCH_SIZE);
    localparam int PPM_W        = 16;
    localparam int LEVEL_W      = 3;
    localparam int MODE_W       = 2;
    localparam int LIMIT_COUNT  = 4;
    localparam int REG_COUNT    = 2 * LIMIT_COUNT;
    localparam int CFG_IDX_W    = $clog2(REG_COUNT);

    localparam int MILLI        = 1000;
    localparam int HALF_MILLI   = 500;
    localparam int EMA_DIV      = 10;
    localparam int EMA_NEW_MUL  = 3;
    localparam int EMA_OLD_MUL  = 7;
    localparam int EMA_ROUND    = 5;

    // average in milli-units: sample * 1000 needs 10 more bits
    localparam int AVG_W        = SAMPLE_WIDTH + 10;
    // 3*m*1000 + 7*avg + 5 stays below 16 times the largest average
    localparam int DIVIDEND_W   = AVG_W + 4;
    localparam int PROD_W       = 2 * DIVIDEND_W;

    // reciprocals ceil(2^s / d): exact for any dividend below 2^DIVIDEND_W (/10)
    // and below 2^AVG_W (/1000), since the rounding excess is at most 2^(s - width)
    localparam int RECIP_SHIFT_10   = DIVIDEND_W + 3;
    localparam int RECIP_SHIFT_1000 = AVG_W + 10;
    localparam logic [DIVIDEND_W-1:0] RECIP_10 =
        DIVIDEND_W'(((64'd1 << RECIP_SHIFT_10) + 64'(EMA_DIV - 1)) / 64'(EMA_DIV));
    localparam logic [DIVIDEND_W-1:0] RECIP_1000 =
        DIVIDEND_W'(((64'd1 << RECIP_SHIFT_1000) + 64'(MILLI - 1)) / 64'(MILLI));

    localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

    localparam logic [PPM_W-1:0] LIMIT_RESET [REG_COUNT] = '{
        16'd800, 16'd1000, 16'd1400, 16'd2000,
        16'd700, 16'd900,  16'd1200, 16'd1600
    };

    typedef logic [LIMIT_COUNT-1:0][PPM_W-1:0] limit_set_t;

    typedef struct packed {
        logic start;
        logic thousand;   // 1: divide by 1000, 0: divide by 10
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // level = 1 + number of limits exceeded up to the first limit not exceeded, where the scan stops
    function automatic logic [LEVEL_W-1:0] classify(input logic [PPM_W-1:0] value,
                                                    input limit_set_t lim);
        logic [LEVEL_W-1:0] lvl;
        logic               stop;
        lvl  = LEVEL_W'(1);
        stop = 1'b0;
        for (int i = 0; i < LIMIT_COUNT; i++)
        begin
            if (!stop)
            begin
                if (value > lim[i])
                    lvl = lvl + LEVEL_W'(1);
                else
                    stop = 1'b1;
            end
        end
        return lvl;
    endfunction

endpackage

// File: sv/m7ec_if.sv
// Valid/ready channel interfaces for the m7ec core: input items and results.
// Depends on m7ec_pkg.
interface m7ec_in_if;
    logic                           valid;
    logic                           ready;
    logic [m7ec_pkg::MODE_W-1:0]    mode;
    logic [m7ec_pkg::PPM_W-1:0]     sample_ppm;
    logic                           profile_select;

    modport source (output valid, output mode, output sample_ppm, output profile_select,
                    input ready);
    modport sink   (input valid, input mode, input sample_ppm, input profile_select,
                    output ready);
endinterface

interface m7ec_out_if;
    logic                           valid;
    logic                           ready;
    logic [m7ec_pkg::PPM_W-1:0]     filtered_ppm;
    logic [m7ec_pkg::LEVEL_W-1:0]   level;
    logic                           cause;
    logic                           last;

    modport source (output valid, output filtered_ppm, output level, output cause,
                    output last, input ready);
    modport sink   (input valid, input filtered_ppm, input level, input cause,
                    input last, output ready);
endinterface

// File: sv/m7ec_divider.sv
// Shared constant divider, divisor 10 or 1000, by reciprocal multiplication.
// Operand registered on start; product registered the next cycle, together with done.
// Depends on m7ec_pkg.
module m7ec_divider
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  m7ec_pkg::div_ctrl_t                 ctrl,
    input  logic [m7ec_pkg::DIVIDEND_W-1:0]     dividend,
    output m7ec_pkg::div_stat_t                 stat,
    output logic [m7ec_pkg::DIVIDEND_W-1:0]     quotient
);

    logic [m7ec_pkg::DIVIDEND_W-1:0] opd_reg, opd_next;
    logic                            thousand_reg, thousand_next;
    logic [m7ec_pkg::PROD_W-1:0]     prod_reg, prod_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [m7ec_pkg::DIVIDEND_W-1:0] recip;
    logic [m7ec_pkg::PROD_W-1:0]     scaled;

    assign recip  = thousand_reg ? m7ec_pkg::RECIP_1000 : m7ec_pkg::RECIP_10;
    // quotient sits above the reciprocal's fraction bits
    assign scaled = thousand_reg ? (prod_reg >> m7ec_pkg::RECIP_SHIFT_1000)
                                 : (prod_reg >> m7ec_pkg::RECIP_SHIFT_10);

    always_comb
    begin
        opd_next      = opd_reg;
        thousand_next = thousand_reg;
        prod_next     = prod_reg;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        if (ctrl.start)
        begin
            opd_next      = dividend;
            thousand_next = ctrl.thousand;
            busy_next     = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = m7ec_pkg::PROD_W'(opd_reg) * m7ec_pkg::PROD_W'(recip);
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opd_reg      <= opd_next;
        thousand_reg <= thousand_next;
        prod_reg     <= prod_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = scaled[m7ec_pkg::DIVIDEND_W-1:0];

endmodule

// File: sv/median7_ema_level_classifier_core.sv
// Flow: a check or restart returns to idle directly; other samples go through insertion, one compare per
// cycle; a batch-closing sample then passes the median state and the shared reciprocal divider, EMA /10
// (skipped for a first batch) and rounding /1000, before its result is emitted. A profile-change result
// is emitted first, in its own state, and either emit waits while the result register is still full.
// Throughput: one item at a time; a new item is taken only when the core is idle again.
// Reset: limits to their defaults, batch empty, no average, first profile selected.
module median7_ema_level_classifier_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [m7ec_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [m7ec_pkg::PPM_W-1:0]          cfg_data,
    m7ec_in_if.sink                             item,
    m7ec_out_if.source                          result
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_EMIT0   = 8'b0000_0010,
        S_INSERT  = 8'b0000_0100,
        S_MEDIAN  = 8'b0000_1000,
        S_DIV10   = 8'b0001_0000,
        S_ROUND   = 8'b0010_0000,
        S_DIV1000 = 8'b0100_0000,
        S_EMIT1   = 8'b1000_0000
    } state_t;

    state_t                                 state_reg, state_next;
    logic [m7ec_pkg::PPM_W-1:0]             limit_reg [m7ec_pkg::REG_COUNT];
    logic [m7ec_pkg::SAMPLE_WIDTH-1:0]      store_reg [m7ec_pkg::BATCH_SIZE];
    logic [m7ec_pkg::SAMPLE_WIDTH-1:0]      store_next [m7ec_pkg::BATCH_SIZE];
    logic [m7ec_pkg::FILL_W-1:0]            fill_reg, fill_next;
    logic [m7ec_pkg::FILL_W-1:0]            j_reg, j_next;
    logic [m7ec_pkg::FILL_W-1:0]            j_prev;
    logic [m7ec_pkg::AVG_W-1:0]             avg_reg, avg_next;
    logic                                   avg_valid_reg, avg_valid_next;
    logic                                   profile_reg, profile_next;
    logic [m7ec_pkg::PPM_W-1:0]             ppm_reg, ppm_next;
    logic [m7ec_pkg::MODE_W-1:0]            mode_reg, mode_next;
    logic [m7ec_pkg::SAMPLE_WIDTH-1:0]      sample_reg, sample_next;
    logic                                   last_reg, last_next;

    logic                                   out_valid_reg, out_valid_next;
    logic [m7ec_pkg::PPM_W-1:0]             out_ppm_reg, out_ppm_next;
    logic [m7ec_pkg::LEVEL_W-1:0]           out_level_reg, out_level_next;
    logic                                   out_cause_reg, out_cause_next;
    logic                                   out_last_reg, out_last_next;

    m7ec_pkg::div_ctrl_t                    div_ctrl;
    m7ec_pkg::div_stat_t                    div_stat;
    logic [m7ec_pkg::DIVIDEND_W-1:0]        div_dividend;
    logic [m7ec_pkg::DIVIDEND_W-1:0]        div_quotient;

    m7ec_pkg::limit_set_t                   lim_set;
    logic [m7ec_pkg::SAMPLE_WIDTH-1:0]      median;
    logic [m7ec_pkg::DIVIDEND_W-1:0]        ema_sum;
    logic [m7ec_pkg::LEVEL_W-1:0]           level_now;
    logic                                   item_xfer;
    logic                                   out_free;

    m7ec_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    always_comb
    begin
        for (int i = 0; i < m7ec_pkg::LIMIT_COUNT; i++)
            lim_set[i] = profile_reg ? limit_reg[i] : limit_reg[i + m7ec_pkg::LIMIT_COUNT];
    end

    assign level_now = m7ec_pkg::classify(ppm_reg, lim_set);
    assign item_xfer = item.valid && item.ready;
    assign out_free  = !out_valid_reg || result.ready;
    assign j_prev    = j_reg - m7ec_pkg::FILL_W'(1);
    assign median    = store_reg[m7ec_pkg::MEDIAN_IDX];
    assign ema_sum   = m7ec_pkg::DIVIDEND_W'(median)
                       * m7ec_pkg::DIVIDEND_W'(m7ec_pkg::EMA_NEW_MUL * m7ec_pkg::MILLI)
                     + m7ec_pkg::DIVIDEND_W'(avg_reg)
                       * m7ec_pkg::DIVIDEND_W'(m7ec_pkg::EMA_OLD_MUL)
                     + m7ec_pkg::DIVIDEND_W'(m7ec_pkg::EMA_ROUND);

    always_comb
    begin
        state_next     = state_reg;
        store_next     = store_reg;
        fill_next      = fill_reg;
        j_next         = j_reg;
        avg_next       = avg_reg;
        avg_valid_next = avg_valid_reg;
        profile_next   = profile_reg;
        ppm_next       = ppm_reg;
        mode_next      = mode_reg;
        sample_next    = sample_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_ppm_next   = out_ppm_reg;
        out_level_next = out_level_reg;
        out_cause_next = out_cause_reg;
        out_last_next  = out_last_reg;
        div_ctrl       = '0;
        div_dividend   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_xfer)
                begin
                    mode_next   = item.mode;
                    sample_next = item.sample_ppm;
                    j_next      = fill_reg;
                    // the profile result is final unless this sample closes a batch
                    last_next   = !(item.mode == m7ec_pkg::MODE_SAMPLE &&
                                    fill_reg == m7ec_pkg::FILL_W'(m7ec_pkg::BATCH_SIZE - 1));
                    if (item.mode == m7ec_pkg::MODE_RESTART)
                    begin
                        fill_next      = '0;
                        avg_valid_next = 1'b0;
                    end
                    if (item.profile_select != profile_reg)
                        profile_next = item.profile_select;
                    if (item.profile_select != profile_reg && avg_valid_reg)
                        state_next = S_EMIT0;
                    else if (item.mode == m7ec_pkg::MODE_SAMPLE)
                        state_next = S_INSERT;
                    else
                        state_next = S_IDLE;
                end
            end
            S_EMIT0:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ppm_next   = ppm_reg;
                    out_level_next = level_now;
                    out_cause_next = 1'b0;
                    out_last_next  = last_reg;
                    state_next     = (mode_reg == m7ec_pkg::MODE_SAMPLE) ? S_INSERT : S_IDLE;
                end
            end
            S_INSERT:
            begin
                // insertion: shift larger entries up one slot per cycle
                if (j_reg != '0 && store_reg[j_prev] > sample_reg)
                begin
                    store_next[j_reg] = store_reg[j_prev];
                    j_next            = j_prev;
                end
                else
                begin
                    store_next[j_reg] = sample_reg;
                    if (fill_reg == m7ec_pkg::FILL_W'(m7ec_pkg::BATCH_SIZE - 1))
                    begin
                        fill_next  = '0;
                        state_next = S_MEDIAN;
                    end
                    else
                    begin
                        fill_next  = fill_reg + m7ec_pkg::FILL_W'(1);
                        state_next = S_IDLE;
                    end
                end
            end
            S_MEDIAN:
            begin
                if (avg_valid_reg)
                begin
                    div_ctrl.start = 1'b1;
                    div_dividend   = ema_sum;
                    state_next     = S_DIV10;
                end
                else
                begin
                    avg_next       = m7ec_pkg::AVG_W'(median)
                                     * m7ec_pkg::AVG_W'(m7ec_pkg::MILLI);
                    avg_valid_next = 1'b1;
                    state_next     = S_ROUND;
                end
            end
            S_DIV10:
            begin
                if (div_stat.done)
                begin
                    avg_next       = div_quotient[m7ec_pkg::AVG_W-1:0];
                    avg_valid_next = 1'b1;
                    state_next     = S_ROUND;
                end
            end
            S_ROUND:
            begin
                div_ctrl.start    = 1'b1;
                div_ctrl.thousand = 1'b1;
                div_dividend      = m7ec_pkg::DIVIDEND_W'(avg_reg)
                                  + m7ec_pkg::DIVIDEND_W'(m7ec_pkg::HALF_MILLI);
                state_next        = S_DIV1000;
            end
            S_DIV1000:
            begin
                if (div_stat.done)
                begin
                    // saturate to the output width
                    if (|div_quotient[m7ec_pkg::DIVIDEND_W-1:m7ec_pkg::PPM_W])
                        ppm_next = '1;
                    else
                        ppm_next = div_quotient[m7ec_pkg::PPM_W-1:0];
                    state_next = S_EMIT1;
                end
            end
            S_EMIT1:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ppm_next   = ppm_reg;
                    out_level_next = level_now;
                    out_cause_next = 1'b1;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            avg_valid_reg <= 1'b0;
            profile_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < m7ec_pkg::REG_COUNT; i++)
                limit_reg[i] <= m7ec_pkg::LIMIT_RESET[i];
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            avg_valid_reg <= avg_valid_next;
            profile_reg   <= profile_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                limit_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg     <= store_next;
        j_reg         <= j_next;
        avg_reg       <= avg_next;
        ppm_reg       <= ppm_next;
        mode_reg      <= mode_next;
        sample_reg    <= sample_next;
        last_reg      <= last_next;
        out_ppm_reg   <= out_ppm_next;
        out_level_reg <= out_level_next;
        out_cause_reg <= out_cause_next;
        out_last_reg  <= out_last_next;
    end

    assign item.ready          = (state_reg == S_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.filtered_ppm = out_ppm_reg;
    assign result.level        = out_level_reg;
    assign result.cause        = out_cause_reg;
    assign result.last         = out_last_reg;

`include "median7_ema_level_classifier_core_assert.svh"

    `M7EC_ASSERT_NOW(a_div_done_in_div_state, div_stat.done,
        (state_reg == S_DIV10 || state_reg == S_DIV1000))
    `M7EC_ASSERT_NOW(a_div_start_when_free, div_ctrl.start, !div_stat.busy)
    `M7EC_ASSERT_NEXT(a_sample_goes_to_work, item_xfer && item.mode == m7ec_pkg::MODE_SAMPLE,
        (state_reg == S_EMIT0 || state_reg == S_INSERT))
    `M7EC_ASSERT_NEXT(a_batch_result_final, state_reg == S_EMIT1 && out_free,
        result.valid && result.cause && result.last && state_reg == S_IDLE)

endmodule

// File: dv/median7_ema_level_classifier_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for median7_ema_level_classifier_core: batch median,
// milli-unit exponential average and five-level classification under random flow control.
// Depends on m7ec_pkg and the m7ec_in_if / m7ec_out_if interfaces.
module median7_ema_level_classifier_core_tb;

    localparam int CLK_HALF      = 2;
    localparam int HANG_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 120;
    localparam int PHASE_ITEMS   = 105;

    localparam logic [m7ec_pkg::MODE_W-1:0] MODE_CHECK = 2'd0;
    localparam logic [m7ec_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam logic SEL_FIRST     = 1'b1;
    localparam logic SEL_SECOND    = 1'b0;
    localparam logic CAUSE_PROFILE = 1'b0;
    localparam logic CAUSE_BATCH   = 1'b1;
    localparam int   FIRST_BASE    = 0;
    localparam int   SECOND_BASE   = m7ec_pkg::LIMIT_COUNT;

    typedef struct packed {
        logic [m7ec_pkg::MODE_W-1:0] mode;
        logic [m7ec_pkg::PPM_W-1:0]  sample_ppm;
        logic                        profile_select;
    } gas_item_t;

    typedef struct packed {
        logic [m7ec_pkg::PPM_W-1:0]   filtered_ppm;
        logic [m7ec_pkg::LEVEL_W-1:0] level;
        logic                         cause;
        logic                         last;
    } level_report_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we;
    logic [m7ec_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [m7ec_pkg::PPM_W-1:0]     cfg_data;

    m7ec_in_if  item();
    m7ec_out_if result();

    median7_ema_level_classifier_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .result    (result)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // predictor state
    logic [m7ec_pkg::PPM_W-1:0]        lim_copy [m7ec_pkg::REG_COUNT];
    logic [m7ec_pkg::PPM_W-1:0]        plan_limits [m7ec_pkg::REG_COUNT];
    logic [m7ec_pkg::SAMPLE_WIDTH-1:0] batch_buf [m7ec_pkg::BATCH_SIZE];
    int unsigned                       batch_cnt;
    longint unsigned                   ema_milli;
    bit                                ema_ready;
    logic                              active_sel;

    gas_item_t     pending_items [$];
    level_report_t due_reports [$];

    int unsigned items_taken = 0;
    int unsigned reports_checked = 0;
    int unsigned fail_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned setting_count = 0;
    logic        in_took = 1'b0;
    int unsigned send_gap = 0;
    int unsigned hold_left = 0;
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;

    // stimulus shaping
    logic        run_sel;
    int          batch_center;

    function automatic void clear_batch();
        for (int i = 0; i < m7ec_pkg::BATCH_SIZE; i++)
            batch_buf[i] = '0;
        batch_cnt = 0;
        ema_milli = 0;
        ema_ready = 1'b0;
    endfunction

    function automatic logic [m7ec_pkg::LEVEL_W-1:0] grade(logic [m7ec_pkg::PPM_W-1:0] ppm);
        int base;
        int n;
        base = active_sel ? FIRST_BASE : SECOND_BASE;
        n = 0;
        while (n < m7ec_pkg::LIMIT_COUNT && ppm > lim_copy[base + n])
            n++;
        return m7ec_pkg::LEVEL_W'(n + 1);
    endfunction

    function automatic level_report_t make_report(logic cause);
        level_report_t   r;
        longint unsigned whole;
        whole = (ema_milli + m7ec_pkg::HALF_MILLI) / m7ec_pkg::MILLI;
        if (whole > 64'hFFFF)
            whole = 64'hFFFF;
        r.filtered_ppm = m7ec_pkg::PPM_W'(whole);
        r.level        = grade(r.filtered_ppm);
        r.cause        = cause;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic void predict_item(gas_item_t it);
        level_report_t                     outs [2];
        int                                n;
        logic [m7ec_pkg::SAMPLE_WIDTH-1:0] sorted [m7ec_pkg::BATCH_SIZE];
        logic [m7ec_pkg::SAMPLE_WIDTH-1:0] x;
        longint unsigned                   med_milli;
        int                                j;
        n = 0;
        if (it.profile_select != active_sel)
        begin
            active_sel = it.profile_select;
            if (ema_ready)
            begin
                outs[n] = make_report(CAUSE_PROFILE);
                n++;
            end
        end
        if (it.mode == m7ec_pkg::MODE_SAMPLE)
        begin
            batch_buf[batch_cnt] = it.sample_ppm;
            batch_cnt++;
            if (batch_cnt == m7ec_pkg::BATCH_SIZE)
            begin
                sorted = batch_buf;
                for (int i = 1; i < m7ec_pkg::BATCH_SIZE; i++)
                begin
                    x = sorted[i];
                    j = i;
                    while (j > 0 && sorted[j - 1] > x)
                    begin
                        sorted[j] = sorted[j - 1];
                        j--;
                    end
                    sorted[j] = x;
                end
                med_milli = 64'(sorted[m7ec_pkg::MEDIAN_IDX]);
                med_milli = med_milli * m7ec_pkg::MILLI;
                if (ema_ready)
                    ema_milli = (m7ec_pkg::EMA_NEW_MUL * med_milli
                                 + m7ec_pkg::EMA_OLD_MUL * ema_milli
                                 + m7ec_pkg::EMA_ROUND) / m7ec_pkg::EMA_DIV;
                else
                    ema_milli = med_milli;
                ema_ready = 1'b1;
                batch_cnt = 0;
                outs[n] = make_report(CAUSE_BATCH);
                n++;
            end
        end
        else if (it.mode == m7ec_pkg::MODE_RESTART)
        begin
            clear_batch();
        end
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                outs[i].last = 1'b1;
            due_reports.push_back(outs[i]);
        end
    endfunction

    // result check, input capture into the predictor, hang watchdog
    always @(posedge clk)
    begin : monitor
        level_report_t want;
        bit            moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (result.valid && result.ready)
            begin
                moved = 1'b1;
                reports_checked++;
                if (due_reports.size() == 0)
                begin
                    $error("unexpected result: filtered_ppm %0d level %0d cause %0d last %0d",
                           result.filtered_ppm, result.level, result.cause, result.last);
                    fail_count++;
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (result.filtered_ppm !== want.filtered_ppm)
                    begin
                        $error("filtered_ppm: expected %0d, got %0d",
                               want.filtered_ppm, result.filtered_ppm);
                        fail_count++;
                    end
                    if (result.level !== want.level)
                    begin
                        $error("level: expected %0d, got %0d", want.level, result.level);
                        fail_count++;
                    end
                    if (result.cause !== want.cause)
                    begin
                        $error("cause: expected %0d, got %0d", want.cause, result.cause);
                        fail_count++;
                    end
                    if (result.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, result.last);
                        fail_count++;
                    end
                end
            end
            if (item.valid && item.ready)
            begin
                moved = 1'b1;
                items_taken++;
                predict_item({item.mode, item.sample_ppm, item.profile_select});
            end
            in_took <= item.valid && item.ready;
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", HANG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic int unsigned idle_span();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge clk)
    begin : driver
        gas_item_t nxt;
        if (rst_n && !(item.valid && !in_took))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                item.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                nxt = pending_items.pop_front();
                item.valid          <= 1'b1;
                item.mode           <= nxt.mode;
                item.sample_ppm     <= nxt.sample_ppm;
                item.profile_select <= nxt.profile_select;
                send_gap = gaps_on ? idle_span() : 0;
            end
            else
            begin
                item.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : receiver
        if (!rst_n)
        begin
            result.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            result.ready <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            hold_left = idle_span();
            result.ready <= 1'b0;
        end
        else
        begin
            result.ready <= 1'b1;
        end
    end

    function automatic void add_item(logic [m7ec_pkg::MODE_W-1:0] m,
                                     logic [m7ec_pkg::PPM_W-1:0] s, logic sel);
        gas_item_t t;
        t.mode           = m;
        t.sample_ppm     = s;
        t.profile_select = sel;
        pending_items.push_back(t);
    endfunction

    // the center of a batch lands near a limit half the time so medians hit the boundaries
    function automatic void pick_center();
        int unsigned roll;
        int          base;
        roll = $urandom_range(0, 99);
        base = run_sel ? FIRST_BASE : SECOND_BASE;
        if (roll < 50)
            batch_center = int'(lim_copy[base + $urandom_range(0, m7ec_pkg::LIMIT_COUNT - 1)])
                           + int'($urandom_range(0, 6)) - 3;
        else if (roll < 80)
            batch_center = $urandom_range(0, 3000);
        else if (roll < 90)
            batch_center = $urandom_range(0, 65535);
        else
            batch_center = ($urandom_range(0, 1) != 0) ? 65535 : 0;
    endfunction

    function automatic logic [m7ec_pkg::PPM_W-1:0] draw_sample();
        int unsigned roll;
        int          v;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            v = batch_center + int'($urandom_range(0, 40)) - 20;
        else if (roll < 82)
            v = $urandom_range(0, 65535);
        else if (roll < 90)
            v = ($urandom_range(0, 1) != 0) ? 65535 : 0;
        else
            v = $urandom_range(0, 3000);
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return m7ec_pkg::PPM_W'(v);
    endfunction

    task automatic queue_random(int unsigned count);
        int unsigned roll;
        for (int unsigned k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                run_sel = ~run_sel;
            if ($urandom_range(0, 6) == 0)
                pick_center();
            roll = $urandom_range(0, 99);
            if (roll < 85)
                add_item(m7ec_pkg::MODE_SAMPLE, draw_sample(), run_sel);
            else if (roll < 92)
                add_item(MODE_CHECK, m7ec_pkg::PPM_W'($urandom_range(0, 65535)), run_sel);
            else if (roll < 96)
                add_item(MODE_SPARE, m7ec_pkg::PPM_W'($urandom_range(0, 65535)), run_sel);
            else
                add_item(m7ec_pkg::MODE_RESTART, m7ec_pkg::PPM_W'($urandom_range(0, 65535)),
                         run_sel);
        end
    endtask

    // four limits of one profile, optionally sorted ascending
    function automatic void plan_profile(int base, int lo, int hi, bit ordered);
        logic [m7ec_pkg::PPM_W-1:0] t;
        for (int i = 0; i < m7ec_pkg::LIMIT_COUNT; i++)
            plan_limits[base + i] = m7ec_pkg::PPM_W'($urandom_range(lo, hi));
        if (ordered)
            for (int i = 0; i < m7ec_pkg::LIMIT_COUNT - 1; i++)
                for (int j = 0; j < m7ec_pkg::LIMIT_COUNT - 1 - i; j++)
                    if (plan_limits[base + j] > plan_limits[base + j + 1])
                    begin
                        t = plan_limits[base + j];
                        plan_limits[base + j] = plan_limits[base + j + 1];
                        plan_limits[base + j + 1] = t;
                    end
    endfunction

    // only called while the block is idle
    task automatic write_limits();
        for (int i = 0; i < m7ec_pkg::REG_COUNT; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= m7ec_pkg::CFG_IDX_W'(i);
            cfg_data  <= plan_limits[i];
            lim_copy[i] = plan_limits[i];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        setting_count++;
    endtask

    task automatic settle();
        while (pending_items.size() != 0 || item.valid || due_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random run with idling, finishing with a stretch of back-to-back transfers
    task automatic run_phase();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        queue_random(PHASE_ITEMS);
        while (pending_items.size() > PHASE_ITEMS / 4)
            @(posedge clk);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        settle();
    endtask

    initial
    begin
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        item.valid          = 1'b0;
        item.mode           = MODE_CHECK;
        item.sample_ppm     = '0;
        item.profile_select = SEL_FIRST;
        result.ready        = 1'b0;

        for (int i = 0; i < m7ec_pkg::REG_COUNT; i++)
            lim_copy[i] = m7ec_pkg::LIMIT_RESET[i];
        clear_batch();
        active_sel    = SEL_FIRST;
        run_sel       = SEL_FIRST;
        batch_center  = 1000;
        setting_count = 1;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // directed part on the reset limits
        add_item(MODE_CHECK, 16'hFFFF, SEL_FIRST);
        add_item(MODE_SPARE, 16'h5A5A, SEL_SECOND);    // profile change with no average
        add_item(m7ec_pkg::MODE_SAMPLE, 16'd65535, SEL_FIRST);
        add_item(m7ec_pkg::MODE_SAMPLE, 16'd0, SEL_FIRST);
        add_item(m7ec_pkg::MODE_SAMPLE, 16'd1200, SEL_FIRST);
        add_item(m7ec_pkg::MODE_SAMPLE, 16'd65535, SEL_FIRST);
        add_item(m7ec_pkg::MODE_SAMPLE, 16'd0, SEL_FIRST);
        add_item(m7ec_pkg::MODE_SAMPLE, 16'd900, SEL_FIRST);
        add_item(m7ec_pkg::MODE_SAMPLE, 16'd1500, SEL_FIRST);    // first batch loads the median
        add_item(MODE_CHECK, 16'h0000, SEL_SECOND);    // re-classification only
        for (int i = 0; i < m7ec_pkg::BATCH_SIZE - 1; i++)
            add_item(m7ec_pkg::MODE_SAMPLE, 16'd65535, SEL_SECOND);
        add_item(m7ec_pkg::MODE_SAMPLE, 16'd65535, SEL_FIRST);   // two results from one item
        add_item(m7ec_pkg::MODE_RESTART, 16'hFFFF, SEL_SECOND);  // result emitted, then cleared
        for (int i = 0; i < m7ec_pkg::BATCH_SIZE; i++)
            add_item(m7ec_pkg::MODE_SAMPLE, 16'd0, SEL_SECOND);
        add_item(m7ec_pkg::MODE_RESTART, 16'h0001, SEL_SECOND);
        add_item(MODE_CHECK, 16'h8000, SEL_FIRST);     // no average after restart
        run_sel = SEL_FIRST;
        settle();

        // ordered limits in the busy range
        plan_profile(FIRST_BASE, 1, 3000, 1'b1);
        plan_profile(SECOND_BASE, 1, 3000, 1'b1);
        write_limits();
        run_phase();

        // extremes of the limit range
        plan_limits[FIRST_BASE + 0] = 16'd1;
        plan_limits[FIRST_BASE + 1] = 16'd2;
        plan_limits[FIRST_BASE + 2] = 16'd65534;
        plan_limits[FIRST_BASE + 3] = 16'd65535;
        for (int i = 0; i < m7ec_pkg::LIMIT_COUNT; i++)
            plan_limits[SECOND_BASE + i] = 16'd1;
        write_limits();
        run_phase();

        // limits in no particular order
        plan_profile(FIRST_BASE, 1, 4000, 1'b0);
        plan_profile(SECOND_BASE, 1, 4000, 1'b0);
        write_limits();
        run_phase();

        // ordered limits over the whole range
        plan_profile(FIRST_BASE, 1, 65535, 1'b1);
        plan_profile(SECOND_BASE, 1, 65535, 1'b1);
        write_limits();
        run_phase();

        $display("Accepted %0d input items under %0d limit settings, checked %0d results.",
                 items_taken, setting_count, reports_checked);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/m7ec_pkg.sv
sv/m7ec_if.sv
sv/m7ec_divider.sv
sv/median7_ema_level_classifier_core.sv
dv/median7_ema_level_classifier_core_tb.sv
